/* sv/rgbs_pkg.sv */
// Package for the RGB 3x3 sharpen stream: payload structs, widths, register codes
// and the per-channel sharpen function. No dependencies.
`default_nettype none

package rgbs_pkg;

    localparam int MAX_LINE  = 2048;              // deepest row supported
    localparam int MAX_ROWS  = 4096;              // tallest frame supported
    localparam int COL_W     = $clog2(MAX_LINE);  // column index / memory address
    localparam int ROW_W     = $clog2(MAX_ROWS);  // row index
    localparam int LW_W      = 12;                // line_width register
    localparam int FH_W      = 13;                // frame_height register
    localparam int CFG_W     = 13;                // widest register
    localparam int PIX_W     = 24;                // packed pixel: red, green, blue

    localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

    // register indexes on the configuration port
    localparam logic CFG_LINE_WIDTH   = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_pix_out;

    // position of the word just accepted, as the scan counter sees it
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             produce;
        logic             frame_end;
    } t_scan_info;

    // both earlier rows of one column live in one memory word
    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line_word;

    // 5*c minus the four neighbors, clamped to 0..255
    function automatic logic [7:0] sharpen_chan(input logic [7:0] c,
                                                input logic [7:0] up,
                                                input logic [7:0] dn,
                                                input logic [7:0] lf,
                                                input logic [7:0] rt);
        logic signed [11:0] s;
        begin
            s = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c})
              - $signed({4'b0000, up}) - $signed({4'b0000, dn})
              - $signed({4'b0000, lf}) - $signed({4'b0000, rt});
            if (s < 0) begin
                sharpen_chan = 8'd0;
            end else if (s > 12'sd255) begin
                sharpen_chan = 8'd255;
            end else begin
                sharpen_chan = s[7:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

/* sv/rgbs_line_mem.sv */
// Line store: one synchronous memory holding rows row-2 and row-1 per column.
// Depends on rgbs_pkg.
`default_nettype none

module rgbs_line_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [rgbs_pkg::COL_W-1:0] i_rd_addr,
    output rgbs_pkg::t_line_word            o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [rgbs_pkg::COL_W-1:0] i_wr_addr,
    input  wire rgbs_pkg::t_line_word       i_wr_data
);

    rgbs_pkg::t_line_word r_mem [rgbs_pkg::MAX_LINE];
    rgbs_pkg::t_line_word r_rd_data;

    // read data holds while no read is issued, so a stalled pipe keeps it
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* sv/rgbs_scan.sv */
// Configuration registers and raster position counter for the sharpen stream.
// Depends on rgbs_pkg.
`default_nettype none

module rgbs_scan (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [rgbs_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                       i_advance,
    output rgbs_pkg::t_scan_info            o_info
);

    logic [rgbs_pkg::LW_W-1:0]  r_line_width;
    logic [rgbs_pkg::FH_W-1:0]  r_frame_height;
    logic [rgbs_pkg::COL_W-1:0] r_col, n_col;
    logic [rgbs_pkg::ROW_W-1:0] r_row, n_row;

    logic [rgbs_pkg::LW_W-1:0]  eff_w;
    logic [rgbs_pkg::FH_W-1:0]  eff_h;
    logic [rgbs_pkg::COL_W-1:0] cur_col;
    logic [rgbs_pkg::ROW_W-1:0] cur_row;
    logic [rgbs_pkg::FH_W-1:0]  row_bump;
    logic [rgbs_pkg::FH_W-1:0]  row_next;
    logic [rgbs_pkg::LW_W-1:0]  col_next;
    logic                       row_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= rgbs_pkg::LW_RESET;
            r_frame_height <= rgbs_pkg::FH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rgbs_pkg::CFG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_data[rgbs_pkg::LW_W-1:0];
                end
                rgbs_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[rgbs_pkg::FH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_line_width < rgbs_pkg::LW_W'(3)) begin
            eff_w = rgbs_pkg::LW_W'(3);
        end else if (r_line_width > rgbs_pkg::LW_W'(rgbs_pkg::MAX_LINE)) begin
            eff_w = rgbs_pkg::LW_W'(rgbs_pkg::MAX_LINE);
        end else begin
            eff_w = r_line_width;
        end
        if (r_frame_height < rgbs_pkg::FH_W'(3)) begin
            eff_h = rgbs_pkg::FH_W'(3);
        end else if (r_frame_height > rgbs_pkg::FH_W'(rgbs_pkg::MAX_ROWS)) begin
            eff_h = rgbs_pkg::FH_W'(rgbs_pkg::MAX_ROWS);
        end else begin
            eff_h = r_frame_height;
        end
    end

    // a position left past the end by a shrunk width/height is wrapped first
    always_comb begin
        row_wrap = ({1'b0, r_col} >= eff_w);
        cur_col  = row_wrap ? '0 : r_col;
        row_bump = {1'b0, r_row} + (row_wrap ? rgbs_pkg::FH_W'(1) : '0);
        cur_row  = (row_bump >= eff_h) ? '0 : row_bump[rgbs_pkg::ROW_W-1:0];

        col_next = {1'b0, cur_col} + rgbs_pkg::LW_W'(1);
        row_next = {1'b0, cur_row} + rgbs_pkg::FH_W'(1);
        if (col_next >= eff_w) begin
            n_col = '0;
            n_row = (row_next >= eff_h) ? '0 : row_next[rgbs_pkg::ROW_W-1:0];
        end else begin
            n_col = col_next[rgbs_pkg::COL_W-1:0];
            n_row = cur_row;
        end

        o_info.col       = cur_col;
        o_info.produce   = (cur_row >= rgbs_pkg::ROW_W'(2)) &&
                           (cur_col >= rgbs_pkg::COL_W'(2));
        o_info.frame_end = ({1'b0, cur_row} == eff_h - rgbs_pkg::FH_W'(1)) &&
                           ({1'b0, cur_col} == eff_w - rgbs_pkg::LW_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

/* sv/rgbs_kernel.sv */
// 3x3 sharpen cross for one pixel, all three channels, combinational.
// Depends on rgbs_pkg.
`default_nettype none

module rgbs_kernel (
    input  wire rgbs_pkg::t_pix  i_c,
    input  wire rgbs_pkg::t_pix  i_up,
    input  wire rgbs_pkg::t_pix  i_dn,
    input  wire rgbs_pkg::t_pix  i_lf,
    input  wire rgbs_pkg::t_pix  i_rt,
    input  wire logic            i_frame_end,
    output rgbs_pkg::t_pix_out   o_pix
);

    always_comb begin
        o_pix.red_out   = rgbs_pkg::sharpen_chan(i_c[23:16], i_up[23:16], i_dn[23:16],
                                                 i_lf[23:16], i_rt[23:16]);
        o_pix.green_out = rgbs_pkg::sharpen_chan(i_c[15:8], i_up[15:8], i_dn[15:8],
                                                 i_lf[15:8], i_rt[15:8]);
        o_pix.blue_out  = rgbs_pkg::sharpen_chan(i_c[7:0], i_up[7:0], i_dn[7:0],
                                                 i_lf[7:0], i_rt[7:0]);
        o_pix.frame_end = i_frame_end;
    end

endmodule

`default_nettype wire

/* sv/rgb_sharpen_3x3_stream.sv */
// Top level of the RGB 3x3 sharpen stream: scan counter, line memory, window
// registers, kernel and output register. Depends on rgbs_pkg, rgbs_scan,
// rgbs_line_mem and rgbs_kernel.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_data  (rgbs_pkg::t_pix_in)
//   output   out        o_valid / i_stall    o_data  (rgbs_pkg::t_pix_out)
//   config   in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One word accepted per clock when the output is not stalled. Each word
// passes a memory read stage and a compute stage into the output register,
// which takes the pixel one row up and one column left of that word. The line memory
// (one read, one write per cycle) sets the one-word-per-clock rate.
// Reset is synchronous; the memory is not cleared, rows are written before
// they are read. A stalled output holds its word; input stalls only when the
// output register is full and stalled and the compute stage holds a result.
`default_nettype none

module rgb_sharpen_3x3_stream (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire rgbs_pkg::t_pix_in          i_data,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output rgbs_pkg::t_pix_out              o_data,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [rgbs_pkg::CFG_W-1:0] i_cfg_data
);

    rgbs_pkg::t_scan_info  scan_info;
    rgbs_pkg::t_line_word  rd_word;
    rgbs_pkg::t_line_word  wr_word;
    rgbs_pkg::t_pix_out    kern_pix;

    // compute stage
    logic                       r_p1_valid;
    logic                       r_p1_produce;
    logic                       r_p1_frame_end;
    logic [rgbs_pkg::COL_W-1:0] r_p1_col;
    rgbs_pkg::t_pix             r_p1_px;

    // window: column col-1 (older, newer, current) and newer of col-2
    rgbs_pkg::t_pix r_w_old1;
    rgbs_pkg::t_pix r_w_new1;
    rgbs_pkg::t_pix r_w_px1;
    rgbs_pkg::t_pix r_w_new2;

    logic               r_out_valid;
    rgbs_pkg::t_pix_out r_out;

    logic adv1;
    logic in_acc;

    assign adv1    = r_p1_valid && (!r_p1_produce || !r_out_valid || !i_stall);
    assign o_stall = r_p1_valid && !adv1;
    assign in_acc  = i_valid && !o_stall;

    rgbs_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_advance  (in_acc),
        .o_info     (scan_info)
    );

    // consecutive words always hit different columns, so the write of one
    // word never meets the read of the next
    assign wr_word.older = rd_word.newer;
    assign wr_word.newer = r_p1_px;

    rgbs_line_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (scan_info.col),
        .o_rd_data (rd_word),
        .i_wr_en   (adv1),
        .i_wr_addr (r_p1_col),
        .i_wr_data (wr_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (in_acc) begin
            r_p1_valid <= 1'b1;
        end else if (adv1) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1_produce   <= scan_info.produce;
            r_p1_frame_end <= scan_info.frame_end;
            r_p1_col       <= scan_info.col;
            r_p1_px        <= {i_data.red_in, i_data.green_in, i_data.blue_in};
        end
    end

    rgbs_kernel u_kernel (
        .i_c         (r_w_new1),
        .i_up        (r_w_old1),
        .i_dn        (r_w_px1),
        .i_lf        (r_w_new2),
        .i_rt        (rd_word.newer),
        .i_frame_end (r_p1_frame_end),
        .o_pix       (kern_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_old1 <= '0;
            r_w_new1 <= '0;
            r_w_px1  <= '0;
            r_w_new2 <= '0;
        end else if (adv1) begin
            r_w_new2 <= r_w_new1;
            r_w_old1 <= rd_word.older;
            r_w_new1 <= rd_word.newer;
            r_w_px1  <= r_p1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv1 && r_p1_produce) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_p1_produce) begin
            r_out <= kern_pix;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire
